### hw/rtl/sxde_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sxde_pkg
// types, codes and constants shared by the sparse xor delta encoder
// ---------------------------------------------------------------------------
package sxde_pkg;

	localparam int unsigned MAX_SLOTS   = 65536;
	localparam int unsigned QDEPTH      = 4;
	localparam int unsigned QPTR_W      = $clog2(QDEPTH);
	localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [16:0] VC_RESET    = 17'd65536;

	localparam logic        ACT_EDIT    = 1'b0;
	localparam logic        ACT_START   = 1'b1;

	localparam logic [1:0]  ST_OK       = 2'd0;
	localparam logic [1:0]  ST_INDEX    = 2'd1;
	localparam logic [1:0]  ST_NONFIN   = 2'd2;

	localparam logic [6:0]  GROUP_MASK  = 7'h7f;

	typedef struct packed {
		logic        action;
		logic [15:0] slot_index;
		logic [63:0] new_bits;
		logic [63:0] base_bits;
	} sxde_in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last;
		logic [1:0]  status;
		logic [16:0] changes_total;
		logic [19:0] payload_total;
	} sxde_out_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [16:0] gap;
		logic [1:0]  gap_len;
		logic [7:0]  mask;
		logic [63:0] diff;
		logic [16:0] chg;
		logic [19:0] pay_base;
	} sxde_job_t;

endpackage : sxde_pkg
`default_nettype wire

### hw/rtl/sxde_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sxde_front
// checks each edit, keeps index and total state, queues one job per change or error
// ---------------------------------------------------------------------------
module sxde_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wen,
	input  wire  [16:0]           cfg_wdata,
	input  wire                   accept,
	input  sxde_pkg::sxde_in_t    edit,
	output logic                  push,
	output sxde_pkg::sxde_job_t   job
);
	import sxde_pkg::*;

	logic [16:0] vc_q;
	logic [16:0] nai_q;
	logic [16:0] lep1_q;
	logic [16:0] chg_q;
	logic [19:0] pay_q;

	logic [16:0] idx_ext;
	logic        idx_err;
	logic        nf_err;
	logic [63:0] diff;
	logic [7:0]  mask;
	logic [3:0]  pop;
	logic [16:0] gap;
	logic [1:0]  glen;
	logic        is_edit;
	logic        ok_change;

	always_comb begin
		idx_ext = {1'b0, edit.slot_index};
		idx_err = (idx_ext < nai_q) || (idx_ext >= vc_q) ||
			(32'(edit.slot_index) >= MAX_SLOTS);
		nf_err  = &edit.new_bits[62:52];
		diff    = edit.new_bits ^ edit.base_bits;
		pop     = '0;
		for (int i = 0; i < 8; i++) begin
			mask[i] = |diff[8*i +: 8];
			pop     = pop + 4'(mask[i]);
		end
		gap = 17'(idx_ext - lep1_q);
		if (|gap[16:14]) begin
			glen = 2'd3;
		end else if (|gap[13:7]) begin
			glen = 2'd2;
		end else begin
			glen = 2'd1;
		end
		is_edit   = accept && (edit.action == ACT_EDIT);
		ok_change = !idx_err && !nf_err && (|mask);
		push      = is_edit && (idx_err || nf_err || (|mask));
	end

	always_comb begin
		job.gap      = gap;
		job.gap_len  = glen;
		job.mask     = mask;
		job.diff     = diff;
		job.pay_base = pay_q;
		if (idx_err) begin
			job.status = ST_INDEX;
			job.chg    = chg_q;
		end else if (nf_err) begin
			job.status = ST_NONFIN;
			job.chg    = chg_q;
		end else begin
			job.status = ST_OK;
			job.chg    = 17'(chg_q + 17'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VC_RESET;
		end else if (cfg_wen) begin
			vc_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nai_q  <= '0;
			lep1_q <= '0;
			chg_q  <= '0;
			pay_q  <= '0;
		end else if (accept && (edit.action == ACT_START)) begin
			nai_q  <= '0;
			lep1_q <= '0;
			chg_q  <= '0;
			pay_q  <= '0;
		end else if (is_edit && !idx_err && !nf_err) begin
			nai_q <= 17'(idx_ext + 17'd1);
			if (ok_change) begin
				lep1_q <= 17'(idx_ext + 17'd1);
				chg_q  <= 17'(chg_q + 17'd1);
				pay_q  <= 20'(pay_q + 20'(glen) + 20'd1 + 20'(pop));
			end
		end
	end

	// an accepted start always leaves the index state cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (edit.action == ACT_START) |=> (nai_q == '0) && (lep1_q == '0))
		else $error("start did not clear state");

	// the last emitted slot never runs ahead of the next allowed index
	assert property (@(posedge clk) disable iff (!arst_n)
		lep1_q <= nai_q)
		else $error("emitted index ahead of allowed index");

	// an error job leaves the change total untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		push && (job.status != ST_OK) |=> $stable(chg_q))
		else $error("error changed totals");

endmodule : sxde_front
`default_nettype wire

### hw/rtl/sxde_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sxde_queue
// short job queue between the front and back parts
// ---------------------------------------------------------------------------
module sxde_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  sxde_pkg::sxde_job_t   wr_job,
	input  wire                   pop,
	output sxde_pkg::sxde_job_t   rd_job,
	output logic                  empty,
	output logic                  full
);
	import sxde_pkg::*;

	sxde_job_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign empty  = (cnt_q == '0);
	assign full   = (cnt_q == QCNT_W'(QDEPTH));
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");

	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("pop from empty queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> !empty)
		else $error("queue lost a job");

endmodule : sxde_queue
`default_nettype wire

### hw/rtl/sxde_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sxde_back
// serialises one job into varint gap, mask and difference bytes or an error byte
// ---------------------------------------------------------------------------
module sxde_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  sxde_pkg::sxde_job_t   head,
	input  wire                   empty,
	output logic                  pop,
	output logic                  code_valid,
	input  wire                   code_stall,
	output sxde_pkg::sxde_out_t   code
);
	import sxde_pkg::*;

	logic        busy_q;
	logic [1:0]  st_q;
	logic [16:0] gap_q;
	logic [1:0]  vleft_q;
	logic        msent_q;
	logic [7:0]  rem_q;
	logic [63:0] diff_q;
	logic [16:0] chg_q;
	logic [19:0] pay_q;
	logic        ovalid_q;
	sxde_out_t   out_q;

	logic        fire;
	logic        done;
	logic [2:0]  sel;
	logic [7:0]  rem_nxt;
	sxde_out_t   word;

	always_comb begin
		sel = '0;
		for (int i = 7; i >= 0; i--) begin
			if (rem_q[i]) begin
				sel = 3'(i);
			end
		end
		rem_nxt      = rem_q & ~(8'd1 << sel);
		word.status  = st_q;
		word.changes_total = chg_q;
		word.payload_total = 20'(pay_q + 20'd1);
		word.last    = 1'b0;
		done         = 1'b0;
		if (st_q != ST_OK) begin
			word.out_byte      = '0;
			word.last          = 1'b1;
			word.payload_total = pay_q;
			done               = 1'b1;
		end else if (vleft_q != '0) begin
			word.out_byte = {(vleft_q > 2'd1), gap_q[6:0] & GROUP_MASK};
		end else if (!msent_q) begin
			word.out_byte = rem_q;
		end else begin
			word.out_byte = diff_q[{sel, 3'b000} +: 8];
			word.last     = (rem_nxt == '0);
			done          = (rem_nxt == '0);
		end
		fire = busy_q && (!ovalid_q || !code_stall);
		pop  = !empty && (!busy_q || (fire && done));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (fire && done) begin
				busy_q <= 1'b0;
			end
			if (fire) begin
				ovalid_q <= 1'b1;
			end else if (!code_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= word;
		end
		if (pop) begin
			st_q    <= head.status;
			gap_q   <= head.gap;
			vleft_q <= head.gap_len;
			msent_q <= 1'b0;
			rem_q   <= head.mask;
			diff_q  <= head.diff;
			chg_q   <= head.chg;
			pay_q   <= head.pay_base;
		end else if (fire && (st_q == ST_OK)) begin
			pay_q <= 20'(pay_q + 20'd1);
			if (vleft_q != '0) begin
				gap_q   <= gap_q >> 7;
				vleft_q <= vleft_q - 2'd1;
			end else if (!msent_q) begin
				msent_q <= 1'b1;
			end else begin
				rem_q <= rem_nxt;
			end
		end
	end

	assign code_valid = ovalid_q;
	assign code       = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> code_valid)
		else $error("issued word not shown");

	assert property (@(posedge clk) disable iff (!arst_n)
		code_valid && (code.status != ST_OK) |-> code.last)
		else $error("error word without last");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !busy_q || (fire && done))
		else $error("job loaded over unfinished job");

endmodule : sxde_back
`default_nettype wire

### hw/rtl/sparse_xor_delta_encoder_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sparse_xor_delta_encoder_top
// sparse xor delta encoder: edits in, varint gap, mask and diff bytes out
// ---------------------------------------------------------------------------
// the first byte of an edit passes through the job queue, the job registers and the output register
// throughput: one byte per cycle while code_stall is low; a change gives 3 to 12
// bytes, an error one byte, and equal words and starts give no bytes
// a four-entry job queue decouples intake from the byte serialiser
// reset clears the control and index state and sets value_count to 65536; no clearing pass
module sparse_xor_delta_encoder_top (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wen,
	input  wire  [16:0]           cfg_wdata,
	input  wire                   edit_valid,
	output logic                  edit_stall,
	input  sxde_pkg::sxde_in_t    edit,
	output logic                  code_valid,
	input  wire                   code_stall,
	output sxde_pkg::sxde_out_t   code
);
	import sxde_pkg::*;

	logic      accept;
	logic      push;
	logic      pop;
	logic      empty;
	logic      full;
	sxde_job_t wr_job;
	sxde_job_t rd_job;

	assign edit_stall = full;
	assign accept     = edit_valid && !full;

	sxde_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.edit      (edit),
		.push      (push),
		.job       (wr_job)
	);

	sxde_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty),
		.full   (full)
	);

	sxde_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (rd_job),
		.empty      (empty),
		.pop        (pop),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code       (code)
	);

endmodule : sparse_xor_delta_encoder_top
`default_nettype wire
